/* hw/rtl/panel_window_write_framer_defines.svh */
// ----------------------------------------------------------------------------
// panel window write framer assertion macros
// Concurrent assertion helpers used by the framer back end.
// ----------------------------------------------------------------------------
`ifndef PANEL_WINDOW_WRITE_FRAMER_DEFINES_SVH
`define PANEL_WINDOW_WRITE_FRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define PWWF_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pwwf assertion failed");
// expression must never be true outside reset
`define PWWF_ASSERT_NEVER(name, expr, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pwwf forbidden condition seen");
`else
`define PWWF_ASSERT(name, prop, clk, rst_n)
`define PWWF_ASSERT_NEVER(name, expr, clk, rst_n)
`endif

`endif

/* hw/rtl/pwwf_pkg.sv */
// ----------------------------------------------------------------------------
// pwwf_pkg
// Types and constants of the panel window write framer.
// ----------------------------------------------------------------------------
package pwwf_pkg;

  // request opcodes
  localparam logic [1:0] OP_WINDOW = 2'd0;
  localparam logic [1:0] OP_PIXEL  = 2'd1;
  localparam logic [1:0] OP_ORIENT = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SWAP_BYTES   = 2'd0;
  localparam logic [1:0] CFG_BGR_ORDER    = 2'd1;
  localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // panel command bytes
  localparam logic [7:0] CMD_COLUMN_ADDR  = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0] CMD_ACCESS_CTRL  = 8'h36;

  localparam logic [7:0] ACCESS_LANDSCAPE = 8'h60;
  localparam logic [7:0] ACCESS_DEFAULT   = 8'h70;
  localparam logic [7:0] ACCESS_BGR_BIT   = 8'h08;

  localparam logic [9:0] LANDSCAPE_WIDTH  = 10'd320;
  localparam logic [9:0] LANDSCAPE_HEIGHT = 10'd240;

  localparam logic       SWAP_RESET   = 1'b1;
  localparam logic       BGR_RESET    = 1'b1;
  localparam logic [9:0] WIDTH_RESET  = 10'd240;
  localparam logic [9:0] HEIGHT_RESET = 10'd240;

  // byte positions within a window run
  localparam logic [3:0] WIN_COL_CMD = 4'd0;
  localparam logic [3:0] WIN_CS_HI   = 4'd1;
  localparam logic [3:0] WIN_CS_LO   = 4'd2;
  localparam logic [3:0] WIN_CE_HI   = 4'd3;
  localparam logic [3:0] WIN_CE_LO   = 4'd4;
  localparam logic [3:0] WIN_ROW_CMD = 4'd5;
  localparam logic [3:0] WIN_RS_HI   = 4'd6;
  localparam logic [3:0] WIN_RS_LO   = 4'd7;
  localparam logic [3:0] WIN_RE_HI   = 4'd8;
  localparam logic [3:0] WIN_RE_LO   = 4'd9;
  localparam logic [3:0] WIN_LAST    = 4'd10;
  localparam logic [3:0] PAIR_LAST   = 4'd1;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] col_start;
    logic [15:0] row_start;
    logic [15:0] col_end;
    logic [15:0] row_end;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic        final_pixel;
  } req_t;

  typedef struct packed {
    logic [7:0] serial_byte;
    logic       is_data;
    logic       run_last;
    logic       area_done;
  } res_t;

  typedef enum logic {
    KIND_WINDOW,
    KIND_PAIR
  } kind_e;

  // classified work between front and back
  typedef struct packed {
    kind_e       kind;
    logic        lead_cmd;
    logic        done;
    logic [63:0] data;
  } desc_t;

endpackage

/* hw/rtl/pwwf_front.sv */
// ----------------------------------------------------------------------------
// pwwf_front
// Holds configuration, takes requests and turns them into work descriptors.
// ----------------------------------------------------------------------------
module pwwf_front
  import pwwf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output desc_t                 q_desc_o
);

  logic       swap_q, swap_d;
  logic       bgr_q, bgr_d;
  logic [9:0] width_q, width_d;
  logic [9:0] height_q, height_d;
  logic       accept;
  logic [7:0] access;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full_i;
  assign accept      = start && !busy;
  assign q_push_o    = accept && (req_i.opcode != OP_NONE);

  always_comb begin
    swap_d   = swap_q;
    bgr_d    = bgr_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SWAP_BYTES:   swap_d   = cfg_data_i[0];
        CFG_BGR_ORDER:    bgr_d    = cfg_data_i[0];
        CFG_PANEL_WIDTH:  width_d  = cfg_data_i;
        CFG_PANEL_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q   <= SWAP_RESET;
      bgr_q    <= BGR_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else begin
      swap_q   <= swap_d;
      bgr_q    <= bgr_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    access = ((width_q == LANDSCAPE_WIDTH) && (height_q == LANDSCAPE_HEIGHT)) ?
             ACCESS_LANDSCAPE : ACCESS_DEFAULT;
    if (bgr_q) begin
      access = access | ACCESS_BGR_BIT;
    end
  end

  always_comb begin
    q_desc_o          = '0;
    q_desc_o.kind     = KIND_PAIR;
    unique case (req_i.opcode)
      OP_WINDOW: begin
        q_desc_o.kind = KIND_WINDOW;
        q_desc_o.data = {req_i.col_start, req_i.col_end, req_i.row_start, req_i.row_end};
      end
      OP_PIXEL: begin
        q_desc_o.done = req_i.final_pixel;
        q_desc_o.data[15:8] = swap_q ? req_i.second_byte : req_i.first_byte;
        q_desc_o.data[7:0]  = swap_q ? req_i.first_byte : req_i.second_byte;
      end
      OP_ORIENT: begin
        q_desc_o.lead_cmd   = 1'b1;
        q_desc_o.data[15:8] = CMD_ACCESS_CTRL;
        q_desc_o.data[7:0]  = access;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/pwwf_fifo.sv */
// ----------------------------------------------------------------------------
// pwwf_fifo
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module pwwf_fifo
  import pwwf_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output desc_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

/* hw/rtl/pwwf_back.sv */
// ----------------------------------------------------------------------------
// pwwf_back
// Walks the head descriptor one byte per cycle into the result register.
// ----------------------------------------------------------------------------
`include "panel_window_write_framer_defines.svh"

module pwwf_back
  import pwwf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  head_valid_i,
  input  desc_t head_i,
  output logic  pop_o,
  output logic  res_valid_o,
  output res_t  res_o
);

  logic [3:0] cnt_q, cnt_d;
  logic       last;
  res_t       res_d;
  logic       res_valid_q;
  res_t       res_q;

  assign last  = (head_i.kind == KIND_PAIR) ? (cnt_q == PAIR_LAST) : (cnt_q == WIN_LAST);
  assign pop_o = head_valid_i && last;

  always_comb begin
    cnt_d = cnt_q;
    if (head_valid_i) begin
      cnt_d = last ? '0 : cnt_q + 1'b1;
    end
  end

  always_comb begin
    res_d           = '0;
    res_d.run_last  = last;
    if (head_i.kind == KIND_PAIR) begin
      res_d.serial_byte = (cnt_q == '0) ? head_i.data[15:8] : head_i.data[7:0];
      res_d.is_data     = (cnt_q == '0) ? !head_i.lead_cmd : 1'b1;
      res_d.area_done   = last && head_i.done;
    end else begin
      res_d.is_data = 1'b1;
      unique case (cnt_q)
        WIN_COL_CMD: begin
          res_d.serial_byte = CMD_COLUMN_ADDR;
          res_d.is_data     = 1'b0;
        end
        WIN_CS_HI:   res_d.serial_byte = head_i.data[63:56];
        WIN_CS_LO:   res_d.serial_byte = head_i.data[55:48];
        WIN_CE_HI:   res_d.serial_byte = head_i.data[47:40];
        WIN_CE_LO:   res_d.serial_byte = head_i.data[39:32];
        WIN_ROW_CMD: begin
          res_d.serial_byte = CMD_ROW_ADDR;
          res_d.is_data     = 1'b0;
        end
        WIN_RS_HI:   res_d.serial_byte = head_i.data[31:24];
        WIN_RS_LO:   res_d.serial_byte = head_i.data[23:16];
        WIN_RE_HI:   res_d.serial_byte = head_i.data[15:8];
        WIN_RE_LO:   res_d.serial_byte = head_i.data[7:0];
        WIN_LAST: begin
          res_d.serial_byte = CMD_MEMORY_WRITE;
          res_d.is_data     = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // a run in progress always has its descriptor at the queue head
  `PWWF_ASSERT(a_run_has_head, (cnt_q != '0) |-> head_valid_i, clk_i, rst_ni)
  `PWWF_ASSERT_NEVER(a_cnt_range, cnt_q > WIN_LAST, clk_i, rst_ni)
  `PWWF_ASSERT(a_done_on_last, (res_valid_o && res_o.area_done) |-> res_o.run_last, clk_i, rst_ni)
  `PWWF_ASSERT(a_pop_strobes, pop_o |=> (res_valid_o && res_o.run_last), clk_i, rst_ni)

endmodule

/* hw/rtl/panel_window_write_framer.sv */
// ----------------------------------------------------------------------------
// panel_window_write_framer
// Serial byte framer for panel window, pixel and orientation requests.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Opcode 0 gives eleven bytes (column command and range, row command and
// range, memory write), opcode 1 gives the two pixel bytes, opcode 2 gives
// the access control command and its byte; opcode 3 is taken and dropped.
// Each byte shows on res_o for one cycle with res_valid_o high; the receiver
// cannot hold it off. The first byte of a request passes through the
// descriptor queue and the result register before it shows on res_o. The
// back end sends one byte per cycle. The descriptor queue (Depth entries)
// lets requests arrive while an earlier one is still being sent; busy is
// high while it is full. Configuration writes on cfg_* are always ready;
// the user must make them only while idle, which the block does not enforce.
// Reset empties the queue, drops any run in progress and loads the register
// defaults: swap on, bgr on, 240 by 240 panel.
// ----------------------------------------------------------------------------
module panel_window_write_framer
  import pwwf_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  res_valid_o,
  output res_t                  res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  desc_t q_desc;
  desc_t q_head;

  pwwf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_desc_o    (q_desc)
  );

  pwwf_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_desc),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  pwwf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

endmodule
